[rtl/core/cspmv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspmv_pkg
// shared types and constants of the complex csr sparse matrix-vector multiplier
// ----------------------------------------------------------------------------
package cspmv_pkg;

   localparam int VALUE_BITS = 16;
   localparam int INDEX_BITS = 10;
   localparam int ROW_BITS   = 16;
   localparam int COUNT_BITS = 17;
   localparam int ACC_BITS   = 40;
   localparam int PROD_BITS  = 2 * VALUE_BITS;
   localparam int TERM_BITS  = PROD_BITS + 1;
   localparam int SUM_BITS   = ACC_BITS + 2;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = PTR_BITS + 1;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_NONZERO = 2'd1,
      MODE_EMPTY   = 2'd2
   } mode_type;

   // item on its way from the vector store read to the multipliers
   typedef struct packed {
      logic                         valid;
      logic                         nonzero;
      logic                         close;
      logic                         in_range;
      logic signed [VALUE_BITS-1:0] re;
      logic signed [VALUE_BITS-1:0] im;
   } stage_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] sum_imag;
      logic signed [ACC_BITS-1:0] sum_real;
      logic [ROW_BITS-1:0]        row_index;
      logic                       last_row;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/cspmv_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspmv_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module cspmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire                      re,
   input  wire  [$clog2(DEPTH)-1:0] addr,
   input  wire  [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/core/cspmv_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspmv_mac
// complex multiply stage and saturating row accumulator with row counter
// ----------------------------------------------------------------------------
module cspmv_mac (
   input  wire                                   clock,
   input  wire                                   reset,
   input  cspmv_pkg::stage_type                  s1,
   input  wire  [2*cspmv_pkg::VALUE_BITS-1:0]    vec_data,
   input  wire  [cspmv_pkg::COUNT_BITS-1:0]      row_count,
   output logic                                  busy,
   output logic                                  res_valid,
   output cspmv_pkg::result_type                 res
);
   import cspmv_pkg::*;

   logic signed [VALUE_BITS-1:0] ar, ai, br, bi;
   logic signed [PROD_BITS-1:0]  rr_in, ii_in, ri_in, ir_in;
   logic signed [PROD_BITS-1:0]  rr_ff, ii_ff, ri_ff, ir_ff;
   logic                         v2_ff, nz2_ff, close2_ff;
   logic signed [TERM_BITS-1:0]  term_re, term_im;
   logic signed [SUM_BITS-1:0]   sum_re, sum_im;
   logic signed [ACC_BITS-1:0]   acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [ACC_BITS-1:0]   next_re, next_im;
   logic [ROW_BITS-1:0]          row_ff, row_in;
   logic                         last_row;

   function automatic logic signed [ACC_BITS-1:0] sat_acc(
      input logic signed [SUM_BITS-1:0] v
   );
      logic [SUM_BITS-ACC_BITS:0] top;
      logic signed [ACC_BITS-1:0] r;
      top = v[SUM_BITS-1:ACC_BITS-1];
      if ((&top) || !(|top)) begin
         r = v[ACC_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         r = {1'b1, {(ACC_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(ACC_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // stage 1: vector element from the store, four partial products
   assign ar = s1.re;
   assign ai = s1.im;
   // column outside the store reads as zero
   assign br = s1.in_range ? vec_data[VALUE_BITS-1:0] : '0;
   assign bi = s1.in_range ? vec_data[2*VALUE_BITS-1:VALUE_BITS] : '0;

   assign rr_in = ar * br;
   assign ii_in = ai * bi;
   assign ri_in = ar * bi;
   assign ir_in = ai * br;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff     <= 1'b0;
         nz2_ff    <= 1'b0;
         close2_ff <= 1'b0;
      end else begin
         v2_ff     <= s1.valid;
         nz2_ff    <= s1.nonzero;
         close2_ff <= s1.close;
      end
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      ri_ff <= ri_in;
      ir_ff <= ir_in;
   end

   // stage 2: accumulate with saturation
   assign term_re = TERM_BITS'(rr_ff) - TERM_BITS'(ii_ff);
   assign term_im = TERM_BITS'(ri_ff) + TERM_BITS'(ir_ff);
   assign sum_re  = SUM_BITS'(acc_re_ff) + SUM_BITS'(term_re);
   assign sum_im  = SUM_BITS'(acc_im_ff) + SUM_BITS'(term_im);
   assign next_re = nz2_ff ? sat_acc(sum_re) : acc_re_ff;
   assign next_im = nz2_ff ? sat_acc(sum_im) : acc_im_ff;

   assign last_row  = (COUNT_BITS'(row_ff) + COUNT_BITS'(1)) == row_count;
   assign res_valid = v2_ff && close2_ff;

   always_comb begin
      res.sum_real  = next_re;
      res.sum_imag  = next_im;
      res.row_index = row_ff;
      res.last_row  = last_row;
   end

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      row_in    = row_ff;
      if (v2_ff) begin
         acc_re_in = close2_ff ? '0 : next_re;
         acc_im_in = close2_ff ? '0 : next_im;
         if (close2_ff) begin
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         row_ff    <= '0;
      end else begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         row_ff    <= row_in;
      end
   end

   assign busy = v2_ff;

endmodule
`default_nettype wire

[rtl/core/cspmv_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspmv_fifo
// small result queue decoupling the accumulator from the result channel
// ----------------------------------------------------------------------------
module cspmv_fifo (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   input  cspmv_pkg::result_type            push_data,
   input  wire                              pop,
   output logic                             head_valid,
   output cspmv_pkg::result_type            head_data,
   output logic [cspmv_pkg::CNT_BITS-1:0]   count
);
   import cspmv_pkg::*;

   result_type          mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_pop;

   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ff];
   assign do_pop     = pop && head_valid;
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + PTR_BITS'(1);
         end
         count_ff <= count_ff + CNT_BITS'(push) - CNT_BITS'(do_pop);
      end
   end

endmodule
`default_nettype wire

[rtl/core/csr_complex_spmv_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csr_complex_spmv_top
// complex sparse matrix times dense vector, rows streamed in csr order
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, sustained. A vector load
// (mode 0) writes the vector store in the cycle it is accepted. A nonzero
// (mode 1) reads the store in its accept cycle, is multiplied in the next
// cycle and is added into the row accumulator in the one after; a row
// result goes from the accumulator into the queue whose head is the rsp
// channel. The rate is set by the accumulator loop, one 42-bit add and
// clamp per cycle, and by the single port of the vector store, which serves
// one load or one lookup per cycle. Back-to-back load then lookup of the same
// element is safe since each access finishes at its own clock edge. Results
// wait in a four-entry queue; req_tready drops only while that queue plus the
// two pipeline stages hold four items, i.e. when the result side stalls.
// Values are Q1.15, sums Q10.30 saturated to 40 bits after every nonzero.
// The vector store has no reset: reading an element never loaded is undefined.
// ----------------------------------------------------------------------------
module csr_complex_spmv_top #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // index[9:0], value_real[25:10], value_imag[41:26], zero pad
   input  wire  [1:0]  req_tuser,   // mode[1:0]
   input  wire         req_tlast,   // last_in_row
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // row_index[15:0], sum_real[55:16], sum_imag[95:56]
   output logic        rsp_tlast,   // last_row
   // register write channel, row_count
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [16:0] csr_data
);
   import cspmv_pkg::*;

   localparam int ADDR_BITS = $clog2(VECTOR_DEPTH);

   // request decode
   mode_type                  mode;
   logic                      accept;
   logic [INDEX_BITS-1:0]     index;
   logic [VALUE_BITS-1:0]     value_real, value_imag;
   logic                      in_range;

   // vector store
   logic                      ram_we, ram_re;
   logic [ADDR_BITS-1:0]      ram_addr;
   logic [2*VALUE_BITS-1:0]   ram_rdata;

   // pipeline and queue
   stage_type                 s1_in, s1_ff;
   logic                      mac_busy;
   logic                      res_valid;
   result_type                res;
   result_type                head;
   logic [CNT_BITS-1:0]       fifo_count;
   logic [CNT_BITS-1:0]       occupancy;

   // configuration
   logic [COUNT_BITS-1:0]     row_count_ff;

   assign mode       = mode_type'(req_tuser);
   assign index      = req_tdata[INDEX_BITS-1:0];
   assign value_real = req_tdata[INDEX_BITS +: VALUE_BITS];
   assign value_imag = req_tdata[INDEX_BITS+VALUE_BITS +: VALUE_BITS];
   assign accept     = req_tvalid && req_tready;
   // columns beyond the store are ignored on load and read as zero
   assign in_range   = 32'(index) < VECTOR_DEPTH;
   assign ram_addr   = ADDR_BITS'(index);

   // credit: every item in flight may need a queue slot
   assign occupancy  = fifo_count + CNT_BITS'(s1_ff.valid) + CNT_BITS'(mac_busy);
   assign req_tready = occupancy < CNT_BITS'(FIFO_DEPTH);

   always_comb begin
      s1_in  = '0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      s1_in.re       = value_real;
      s1_in.im       = value_imag;
      s1_in.in_range = in_range;
      if (accept) begin
         unique case (mode)
            MODE_LOAD: begin
               ram_we = in_range;
            end
            MODE_NONZERO: begin
               ram_re        = 1'b1;
               s1_in.valid   = 1'b1;
               s1_in.nonzero = 1'b1;
               s1_in.close   = req_tlast;
            end
            MODE_EMPTY: begin
               s1_in.valid = 1'b1;
               s1_in.close = 1'b1;
            end
            default: begin
               // unused mode, dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   cspmv_ram #(
      .WIDTH (2 * VALUE_BITS),
      .DEPTH (VECTOR_DEPTH)
   ) u_vec_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata ({value_imag, value_real}),
      .rdata (ram_rdata)
   );

   cspmv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .s1        (s1_ff),
      .vec_data  (ram_rdata),
      .row_count (row_count_ff),
      .busy      (mac_busy),
      .res_valid (res_valid),
      .res       (res)
   );

   cspmv_fifo u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (head),
      .count      (fifo_count)
   );

   assign rsp_tdata = {head.sum_imag, head.sum_real, head.row_index};
   assign rsp_tlast = head.last_row;

   // row_count register; the user must write it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= COUNT_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         row_count_ff <= csr_data;
      end
   end

`ifndef NO_ASSERTIONS
   // the credit never lets the queue plus the pipeline exceed the queue depth
   assert property (@(posedge clock) disable iff (reset)
      occupancy <= CNT_BITS'(FIFO_DEPTH))
      else $error("result queue credit exceeded");

   // a queue push only happens when the queue has room
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> fifo_count < CNT_BITS'(FIFO_DEPTH))
      else $error("push into full result queue");

   // an accepted nonzero passes the s1 register and then reaches the accumulator stage
   assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_NONZERO) |-> ##2 mac_busy)
      else $error("nonzero lost in pipeline");

   // a result flagged as last row carries the row before row_count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (COUNT_BITS'(head.row_index) + COUNT_BITS'(1)) == row_count_ff)
      else $error("last row flag inconsistent with row index");
`endif

endmodule
`default_nettype wire

[bench/csr_complex_spmv_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_complex_spmv_top_tb
// self-checking bench for the complex csr sparse matrix-vector multiplier
// ----------------------------------------------------------------------------
// directed table first: vector loads at both ends of the store, closing and
// open nonzeros, empty rows, the unused mode, mid-row loads
// random traffic next over several row_count settings, including 0, 1 and the
// largest, plus one very long row that pins the accumulator at a rail of
// random polarity
// every accepted request goes through a local predictor, each row result is
// checked field by field against the oldest pending expectation
// sender bursts and receiver stalls are randomized
// ----------------------------------------------------------------------------
module csr_complex_spmv_top_tb;
   import cspmv_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         DEPTH       = 1024;
   // longer than the pipeline takes to drain
   localparam int         PIPE_DRAIN  = 8;
   localparam longint     SUM_MAX     = (64'sd1 <<< (ACC_BITS - 1)) - 1;
   localparam longint     SUM_MIN     = -SUM_MAX - 1;

   typedef struct packed {
      logic [ROW_BITS-1:0]        row;
      logic signed [ACC_BITS-1:0] re;
      logic signed [ACC_BITS-1:0] im;
      logic                       last;
   } row_sum_type;

   // one request transaction; typed marks a hand-written expected row sum
   typedef struct packed {
      logic [1:0]            mode;
      logic [INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0] re;
      logic [VALUE_BITS-1:0] im;
      logic                  last;
      logic                  typed;
      row_sum_type           sum;
   } req_item_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_SPARSE,
      RX_BLOCKED
   } rx_style_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // index[9:0], value_real[25:10], value_imag[41:26], zero pad
   logic [1:0]  req_tuser  = '0;   // mode[1:0]
   logic        req_tlast  = 1'b0; // last_in_row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // row_index[15:0], sum_real[55:16], sum_imag[95:56]
   logic        rsp_tlast;         // last_row
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data   = '0;   // row_count

   csr_complex_spmv_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // generous ceiling: the slowest legal run needs well under a tenth of this
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor state
   // ------------------------------------------------------------------------
   logic signed [VALUE_BITS-1:0] vec_re [DEPTH];
   logic signed [VALUE_BITS-1:0] vec_im [DEPTH];
   longint                       acc_re    = 0;
   longint                       acc_im    = 0;
   logic [ROW_BITS-1:0]          row_ctr   = '0;
   logic [COUNT_BITS-1:0]        row_total = 17'd1;

   row_sum_type row_sums_due [$];
   int          mismatches = 0;

   // stimulus bookkeeping: only columns already loaded are ever looked up
   bit loaded [DEPTH];
   int loaded_cols [$];
   int burst_left = 0;

   function automatic longint clip_sum(input longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
   endfunction

   // advance the predictor by one accepted request; returns 1 when a row closes
   function automatic bit spmv_step(input req_item_type it, output row_sum_type res);
      longint vr, vi, br, bi;
      bit     close;
      res   = '0;
      close = 1'b0;
      vr    = $signed(it.re);
      vi    = $signed(it.im);
      case (it.mode)
         MODE_LOAD: begin
            vec_re[it.index] = it.re;
            vec_im[it.index] = it.im;
         end
         MODE_NONZERO: begin
            br     = vec_re[it.index];
            bi     = vec_im[it.index];
            // exact complex product added in, then clamped to 40 bits
            acc_re = clip_sum(acc_re + (vr * br - vi * bi));
            acc_im = clip_sum(acc_im + (vr * bi + vi * br));
            close  = it.last;
         end
         MODE_EMPTY: close = 1'b1;
         default: ;
      endcase
      if (close) begin
         res.row  = row_ctr;
         res.re   = acc_re[ACC_BITS-1:0];
         res.im   = acc_im[ACC_BITS-1:0];
         res.last = ({1'b0, row_ctr} + 17'd1) == row_total;
         acc_re   = 0;
         acc_im   = 0;
         row_ctr  = res.last ? '0 : row_ctr + 1'b1;
      end
      return close;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // bursts of random length with random gaps; tvalid stays high inside a burst
   task automatic issue_request(input req_item_type it);
      row_sum_type res;
      int          gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (it.mode == MODE_LOAD && !loaded[it.index]) begin
         loaded[it.index] = 1'b1;
         loaded_cols      = {loaded_cols, int'(it.index)};
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tlast  <= it.last;
      req_tdata  <= {6'b0, it.im, it.re, it.index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (spmv_step(it, res)) row_sums_due = {row_sums_due, it.typed ? it.sum : res};
   endtask

   // sender holds off until every pending row sum has been received
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (row_sums_due.size() != 0);
   endtask

   task automatic write_row_count(input logic [16:0] rows);
      drain();
      // let non-closing transactions still in the pipeline settle
      repeat (PIPE_DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      row_total = rows;
   endtask

   function automatic req_item_type make_item(input logic [1:0] mode,
                                              input logic [INDEX_BITS-1:0] index,
                                              input logic [VALUE_BITS-1:0] re,
                                              input logic [VALUE_BITS-1:0] im,
                                              input logic last);
      req_item_type it;
      it       = '0;
      it.mode  = mode;
      it.index = index;
      it.re    = re;
      it.im    = im;
      it.last  = last;
      return it;
   endfunction

   // extremes show up often so that products hit the corners
   function automatic logic [VALUE_BITS-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [INDEX_BITS-1:0] pick_col();
      return INDEX_BITS'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
   endfunction

   task automatic random_load();
      issue_request(make_item(MODE_LOAD, INDEX_BITS'($urandom_range(0, DEPTH - 1)),
                              rand_value(), rand_value(), 1'($urandom_range(0, 1))));
   endtask

   // one row of nonzeros, now and then with a load or unused-mode noise inside,
   // and rarely left open so the next row inherits its partial sum
   task automatic random_row(output int count);
      int  n;
      bit  open_row;
      n        = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      open_row = ($urandom_range(0, 19) == 0);
      count    = n;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 11))
            0: begin
               random_load();
               count++;
            end
            1: issue_request(make_item(MODE_UNUSED, INDEX_BITS'($urandom),
                                       VALUE_BITS'($urandom), VALUE_BITS'($urandom),
                                       1'($urandom_range(0, 1))));
            default: ;
         endcase
         issue_request(make_item(MODE_NONZERO, pick_col(), rand_value(), rand_value(),
                                 (i == n - 1) && !open_row));
      end
   endtask

   // long row of worst-case products so the accumulator pins at a rail,
   // then three random terms, the last of which closes the row
   task automatic saturating_row(input bit upward);
      logic [INDEX_BITS-1:0] col;
      int                    n;
      col = INDEX_BITS'($urandom_range(0, DEPTH - 1));
      issue_request(make_item(MODE_LOAD, col, 16'h8000, 16'h8000, 1'b0));
      n = $urandom_range(258, 270);
      repeat (n)
         issue_request(make_item(MODE_NONZERO, col, upward ? 16'h8000 : 16'h7fff,
                                 upward ? 16'h7fff : 16'h8000, 1'b0));
      for (int i = 0; i < 3; i++)
         issue_request(make_item(MODE_NONZERO, pick_col(), rand_value(), rand_value(),
                                 i == 2));
   endtask

   // mostly well-formed rows, with loads, empty rows and unused-mode noise
   task automatic random_phase(input int budget);
      int done;
      int pick;
      int n;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 15 || loaded_cols.size() == 0) begin
            random_load();
            done++;
         end else if (pick < 25) begin
            issue_request(make_item(MODE_EMPTY, INDEX_BITS'($urandom),
                                    VALUE_BITS'($urandom), VALUE_BITS'($urandom),
                                    1'($urandom_range(0, 1))));
            done++;
         end else if (pick < 30) begin
            // ignored by the block, not counted
            issue_request(make_item(MODE_UNUSED, INDEX_BITS'($urandom),
                                    VALUE_BITS'($urandom), VALUE_BITS'($urandom),
                                    1'($urandom_range(0, 1))));
         end else begin
            random_row(n);
            done += n;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // directed table; row_count is still 1 from reset, so every row is last
   // ------------------------------------------------------------------------
   req_item_type plan [17] = '{
      // empty row straight after reset
      '{MODE_EMPTY,   10'd0,    16'h0000, 16'h0000, 1'b0, 1'b1,
        '{16'd0, 40'sd0, 40'sd0, 1'b1}},
      // unused mode with everything set
      '{MODE_UNUSED,  10'd1023, 16'hffff, 16'hffff, 1'b1, 1'b0, '0},
      '{MODE_LOAD,    10'd0,    16'h7fff, 16'h7fff, 1'b0, 1'b0, '0},
      // tlast on a load is ignored
      '{MODE_LOAD,    10'd1023, 16'h8000, 16'h8000, 1'b1, 1'b0, '0},
      '{MODE_LOAD,    10'd1,    16'h8000, 16'h7fff, 1'b0, 1'b0, '0},
      '{MODE_NONZERO, 10'd0,    16'h7fff, 16'h7fff, 1'b1, 1'b0, '0},
      '{MODE_NONZERO, 10'd1023, 16'h8000, 16'h8000, 1'b1, 1'b0, '0},
      '{MODE_NONZERO, 10'd1,    16'h8000, 16'h7fff, 1'b0, 1'b0, '0},
      // reload of a column in the middle of a row
      '{MODE_LOAD,    10'd1,    16'hffff, 16'h0001, 1'b1, 1'b0, '0},
      '{MODE_NONZERO, 10'd1,    16'h0001, 16'h0001, 1'b1, 1'b0, '0},
      '{MODE_NONZERO, 10'd0,    16'h8000, 16'h0000, 1'b0, 1'b0, '0},
      '{MODE_UNUSED,  10'd0,    16'h0000, 16'h0000, 1'b0, 1'b0, '0},
      // empty row closing a partial sum
      '{MODE_EMPTY,   10'd0,    16'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{MODE_LOAD,    10'd512,  16'h0000, 16'h0000, 1'b0, 1'b0, '0},
      // extreme nonzero times a zero element
      '{MODE_NONZERO, 10'd512,  16'h7fff, 16'h8000, 1'b1, 1'b1,
        '{16'd0, 40'sd0, 40'sd0, 1'b1}},
      '{MODE_NONZERO, 10'd1023, 16'h7fff, 16'h8000, 1'b0, 1'b0, '0},
      '{MODE_NONZERO, 10'd1023, 16'h7fff, 16'h8000, 1'b1, 1'b0, '0}
   };

   initial begin
      logic [16:0] phase_rows [7];
      phase_rows = '{17'd3, 17'd65536, 17'd0, 17'd2, 17'd1, 17'd7, 17'd0};
      // one setting beyond the row counter range, sets the top csr bit
      phase_rows[6] = 17'($urandom_range(65537, 131071));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) issue_request(plan[i]);

      foreach (phase_rows[p]) begin
         write_row_count(phase_rows[p]);
         if (p == 1) saturating_row(1'($urandom_range(0, 1)));
         random_phase(20);
      end

      drain();
      repeat (2 * PIPE_DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   // receiver pattern: open, sparse stalls, or long blocks that back up the
   // result queue far enough to drop req_tready
   int           rx_cycle = 0;
   int           rx_hold  = 0;
   rx_style_type rx_style = RX_OPEN;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_style = rx_style_type'($urandom_range(0, 2));
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  rx_hold = $urandom_range(2, 14);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // compare each accepted row result with the oldest pending one
   always @(posedge clock) begin : check_rows
      row_sum_type                want;
      logic signed [ACC_BITS-1:0] got_re;
      logic signed [ACC_BITS-1:0] got_im;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_re = rsp_tdata[55:16];
         got_im = rsp_tdata[95:56];
         if (row_sums_due.size() == 0) begin
            $error("unexpected row result, row_index %0d", rsp_tdata[15:0]);
            mismatches++;
         end else begin
            want = row_sums_due.pop_front();
            if (rsp_tdata[15:0] !== want.row) begin
               $error("row_index: expected %0d, got %0d", want.row, rsp_tdata[15:0]);
               mismatches++;
            end
            if (got_re !== want.re) begin
               $error("sum_real: expected %0d, got %0d", want.re, got_re);
               mismatches++;
            end
            if (got_im !== want.im) begin
               $error("sum_imag: expected %0d, got %0d", want.im, got_im);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_row: expected %0d, got %0d", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

endmodule

[sim.f]
rtl/core/cspmv_pkg.sv
rtl/core/cspmv_ram.sv
rtl/core/cspmv_mac.sv
rtl/core/cspmv_fifo.sv
rtl/core/csr_complex_spmv_top.sv
bench/csr_complex_spmv_top_tb.sv
